### rtl/iraft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR air-conditioner frame transmitter - shared definitions
// Item types, timing bundle, segment states, register indexes and frame bytes.
// ----------------------------------------------------------------------------
package iraft_pkg;

    localparam int FRAME_BYTES_DEF = 14;
    localparam int LEN_W           = 14;
    localparam int PER_W           = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SPACE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd5;

    localparam logic [LEN_W-1:0] RST_HDR_MARK   = 14'd3600;
    localparam logic [LEN_W-1:0] RST_HDR_SPACE  = 14'd1630;
    localparam logic [LEN_W-1:0] RST_ONE_SPACE  = 14'd1380;
    localparam logic [LEN_W-1:0] RST_ZERO_SPACE = 14'd420;
    localparam logic [LEN_W-1:0] RST_BIT_MARK   = 14'd420;
    localparam logic [PER_W-1:0] RST_PERIOD     = 8'd26;
    localparam logic [PER_W-1:0] MIN_PERIOD     = 8'd2;

    localparam logic [7:0] HDR_BYTE0 = 8'h23;
    localparam logic [7:0] HDR_BYTE1 = 8'hCB;
    localparam logic [7:0] HDR_BYTE2 = 8'h26;
    localparam logic [7:0] CMD_BYTE3 = 8'h01;
    localparam logic [4:0] TEMP_TOP  = 5'd31;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_LEAD_MARK,
        PH_BIT_SPACE,
        PH_BIT_MARK
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] power_code;
        logic [7:0] mode_code;
        logic [4:0] temperature;
        logic [7:0] fan_speed_code;
        logic [7:0] vane_vert_code;
        logic [7:0] vane_horz_code;
    } t_in_item;

    typedef struct packed {
        logic led_level;
        logic busy_res;
        logic frame_end;
        logic send_ignored;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0] hdr_burst;
        logic [LEN_W-1:0] hdr_gap;
        logic [LEN_W-1:0] one_gap;
        logic [LEN_W-1:0] zero_gap;
        logic [LEN_W-1:0] bit_burst;
        logic [PER_W-1:0] period;
    } t_timing;

endpackage

### rtl/iraft_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR frame transmitter - timing registers
// Holds the length and carrier registers and presents their effective values.
// ----------------------------------------------------------------------------
module iraft_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [iraft_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [iraft_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output iraft_pkg::t_timing                  o_timing
);
    import iraft_pkg::*;

    logic [LEN_W-1:0] r_hdr_burst, r_hdr_gap, r_one_gap, r_zero_gap, r_bit_burst;
    logic [PER_W-1:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_burst <= RST_HDR_MARK;
            r_hdr_gap   <= RST_HDR_SPACE;
            r_one_gap   <= RST_ONE_SPACE;
            r_zero_gap  <= RST_ZERO_SPACE;
            r_bit_burst <= RST_BIT_MARK;
            r_period    <= RST_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HDR_MARK:   r_hdr_burst <= i_cfg_data;
                CFG_HDR_SPACE:  r_hdr_gap   <= i_cfg_data;
                CFG_ONE_SPACE:  r_one_gap   <= i_cfg_data;
                CFG_ZERO_SPACE: r_zero_gap  <= i_cfg_data;
                CFG_BIT_MARK:   r_bit_burst <= i_cfg_data;
                CFG_PERIOD:     r_period    <= i_cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    // zero length reads as one, period floors at two
    always_comb begin
        o_timing.hdr_burst = (r_hdr_burst == '0) ? LEN_W'(1) : r_hdr_burst;
        o_timing.hdr_gap   = (r_hdr_gap   == '0) ? LEN_W'(1) : r_hdr_gap;
        o_timing.one_gap   = (r_one_gap   == '0) ? LEN_W'(1) : r_one_gap;
        o_timing.zero_gap  = (r_zero_gap  == '0) ? LEN_W'(1) : r_zero_gap;
        o_timing.bit_burst = (r_bit_burst == '0) ? LEN_W'(1) : r_bit_burst;
        o_timing.period    = (r_period < MIN_PERIOD) ? MIN_PERIOD : r_period;
    end

endmodule

### rtl/iraft_frame_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR frame transmitter - frame builder
// Assembles the command frame and its checksum from a send item.
// ----------------------------------------------------------------------------
module iraft_frame_build #(
    parameter int FRAME_BYTES = iraft_pkg::FRAME_BYTES_DEF
) (
    input  iraft_pkg::t_in_item         i_item,
    output logic [FRAME_BYTES*8-1:0]    o_frame
);
    import iraft_pkg::*;

    logic [7:0] temp_byte, fan_byte, csum;

    always_comb begin
        temp_byte = {3'b000, TEMP_TOP - i_item.temperature};
        fan_byte  = i_item.fan_speed_code | i_item.vane_vert_code;
        csum      = HDR_BYTE0 + HDR_BYTE1 + HDR_BYTE2 + CMD_BYTE3
                  + i_item.power_code + i_item.mode_code + temp_byte
                  + fan_byte + i_item.vane_horz_code;

        o_frame          = '0;
        o_frame[7:0]     = HDR_BYTE0;
        o_frame[15:8]    = HDR_BYTE1;
        o_frame[23:16]   = HDR_BYTE2;
        o_frame[31:24]   = CMD_BYTE3;
        o_frame[47:40]   = i_item.power_code;
        o_frame[55:48]   = i_item.mode_code;
        o_frame[63:56]   = temp_byte;
        o_frame[71:64]   = fan_byte;
        o_frame[103:96]  = i_item.vane_horz_code;
        o_frame[111:104] = csum;
    end

endmodule

### rtl/iraft_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR frame transmitter - segment sequencer
// Walks header, lead and bit segments, times them and drives the carrier.
// ----------------------------------------------------------------------------
module iraft_sequencer #(
    parameter int FRAME_BYTES = iraft_pkg::FRAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  iraft_pkg::t_in_item         i_item,
    input  logic [FRAME_BYTES*8-1:0]    i_frame,
    input  iraft_pkg::t_timing          i_timing,
    output iraft_pkg::t_out_item        o_res
);
    import iraft_pkg::*;

    localparam int NBITS = FRAME_BYTES * 8;
    localparam int CNT_W = $clog2(NBITS);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(NBITS - 1);

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_time, n_time;
    logic [PER_W-1:0]   r_carrier, n_carrier;
    logic [PER_W-1:0]   r_mark_per, n_mark_per;
    logic [PER_W-1:0]   r_round, n_round;
    logic [CNT_W-1:0]   r_bitcnt, n_bitcnt;
    logic [NBITS-1:0]   r_bits, n_bits;

    logic               is_mark, car_wrap, round_wrap, seg_end, busy;
    logic [LEN_W-1:0]   time_dec;
    logic [PER_W-1:0]   car_now;
    logic [PER_W:0]     car_inc, round_inc;

    // a mark runs until its length is spent and the period latched at its start wraps
    always_comb begin
        busy       = (r_phase != PH_IDLE);
        is_mark    = (r_phase == PH_HDR_MARK) || (r_phase == PH_LEAD_MARK)
                  || (r_phase == PH_BIT_MARK);
        car_now    = (r_carrier >= i_timing.period) ? '0 : r_carrier;
        car_inc    = {1'b0, car_now} + (PER_W+1)'(1);
        car_wrap   = (car_inc >= {1'b0, i_timing.period});
        round_inc  = {1'b0, r_round} + (PER_W+1)'(1);
        round_wrap = (round_inc >= {1'b0, r_mark_per});
        time_dec   = (r_time == '0) ? '0 : r_time - LEN_W'(1);
        seg_end    = (time_dec == '0) && (!is_mark || round_wrap);
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_time     = r_time;
        n_carrier  = r_carrier;
        n_mark_per = r_mark_per;
        n_round    = r_round;
        n_bitcnt   = r_bitcnt;
        n_bits     = r_bits;
        if (i_item.kind) begin
            if (!busy) begin
                n_phase    = PH_HDR_MARK;
                n_time     = i_timing.hdr_burst;
                n_carrier  = '0;
                n_mark_per = i_timing.period;
                n_round    = '0;
                n_bitcnt   = '0;
                n_bits     = i_frame;
            end
        end else if (busy) begin
            n_time = time_dec;
            if (is_mark) begin
                n_carrier = car_wrap ? '0 : car_inc[PER_W-1:0];
                n_round   = round_wrap ? '0 : round_inc[PER_W-1:0];
            end
            if (seg_end) begin
                case (r_phase)
                    PH_HDR_MARK: begin
                        n_phase = PH_HDR_SPACE;
                        n_time  = i_timing.hdr_gap;
                    end
                    PH_HDR_SPACE: begin
                        n_phase    = PH_LEAD_MARK;
                        n_time     = i_timing.bit_burst;
                        n_carrier  = '0;
                        n_mark_per = i_timing.period;
                        n_round    = '0;
                    end
                    PH_LEAD_MARK: begin
                        n_phase  = PH_BIT_SPACE;
                        n_bitcnt = '0;
                        n_time   = r_bits[0] ? i_timing.one_gap : i_timing.zero_gap;
                    end
                    PH_BIT_SPACE: begin
                        n_phase    = PH_BIT_MARK;
                        n_time     = i_timing.bit_burst;
                        n_carrier  = '0;
                        n_mark_per = i_timing.period;
                        n_round    = '0;
                    end
                    PH_BIT_MARK: begin
                        if (r_bitcnt == LAST_BIT) begin
                            n_phase   = PH_IDLE;
                            n_bitcnt  = '0;
                            n_carrier = '0;
                        end else begin
                            n_phase  = PH_BIT_SPACE;
                            n_bitcnt = r_bitcnt + CNT_W'(1);
                            n_bits   = r_bits >> 1;
                            n_time   = r_bits[1] ? i_timing.one_gap
                                                 : i_timing.zero_gap;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // result
    always_comb begin
        o_res = '0;
        if (i_item.kind) begin
            o_res.busy_res     = 1'b1;
            o_res.send_ignored = busy;
        end else if (busy) begin
            o_res.busy_res  = 1'b1;
            o_res.led_level = is_mark && (car_now < (i_timing.period >> 1));
            o_res.frame_end = seg_end && (r_phase == PH_BIT_MARK)
                           && (r_bitcnt == LAST_BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_time     <= '0;
            r_carrier  <= '0;
            r_mark_per <= MIN_PERIOD;
            r_round    <= '0;
            r_bitcnt   <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_time     <= n_time;
            r_carrier  <= n_carrier;
            r_mark_per <= n_mark_per;
            r_round    <= n_round;
            r_bitcnt   <= n_bitcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_bits <= n_bits;
        end
    end

endmodule

### rtl/ir_aircon_frame_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR air-conditioner frame transmitter - top level
// Pulse-distance IR frame generator driven by one-microsecond tick items.
//
//   channel | direction | handshake                    | payload
//   in      | input     | i_in_valid / o_in_stall      | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall    | o_out_data (t_out_item)
//   cfg     | input     | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
// One item per cycle unless the output stalls; each accepted item passes the
// input register, then the result register behind the sequencer logic.
// Reset is synchronous and returns the sequencer to idle and timing to defaults.
// A stall on the output holds the result register and then the input register.
// ----------------------------------------------------------------------------
module ir_aircon_frame_transmitter #(
    parameter int FRAME_BYTES = iraft_pkg::FRAME_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  iraft_pkg::t_in_item                 i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output iraft_pkg::t_out_item                o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_we,
    input  logic [iraft_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [iraft_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import iraft_pkg::*;

    logic                       r_in_valid, n_in_valid;
    t_in_item                   r_in_item;
    logic                       r_out_valid, n_out_valid;
    t_out_item                  r_out_data;
    logic                       adv, in_take, step;
    t_timing                    timing;
    t_out_item                  res;
    logic [FRAME_BYTES*8-1:0]   frame;

    always_comb begin
        adv         = !r_out_valid || !i_out_stall;
        o_in_stall  = r_in_valid && !adv;
        in_take     = i_in_valid && !o_in_stall;
        step        = r_in_valid && adv;
        n_in_valid  = in_take ? 1'b1 : (adv ? 1'b0 : r_in_valid);
        n_out_valid = adv ? r_in_valid : r_out_valid;
    end

    iraft_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_timing   (timing)
    );

    iraft_frame_build #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_build (
        .i_item  (r_in_item),
        .o_frame (frame)
    );

    iraft_sequencer #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_frame  (frame),
        .i_timing (timing),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_data;
        end
        if (step) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### verif/ir_aircon_frame_transmitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR air-conditioner frame transmitter - testbench
// Drives send and tick items with random gaps and output stalls, predicts the
// LED waveform and status flags of every item and checks each result field.
// Covers idle items after reset, zero lengths, tiny and maximum carrier
// periods, ignored sends and timing changes in the middle of a frame.
// ----------------------------------------------------------------------------
module ir_aircon_frame_transmitter_tb;
    import iraft_pkg::*;

    localparam int FRAME_N    = FRAME_BYTES_DEF;
    localparam int WDOG_LIMIT = 4000;
    localparam int MAX_PRINTS = 50;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    t_in_item  tx_item_q [$];
    t_out_item exp_wave_q [$];

    // predicted transmitter state
    t_timing     tmg = '{RST_HDR_MARK, RST_HDR_SPACE, RST_ONE_SPACE, RST_ZERO_SPACE,
                         RST_BIT_MARK, RST_PERIOD};
    logic [7:0]  frame_img [FRAME_N] = '{default: 8'h00};
    t_phase      seq_ph    = PH_IDLE;
    int unsigned bit_pos   = 0;
    int unsigned ticks_left = 0;
    int unsigned car_ph    = 0;

    logic        in_took = 1'b0, out_took = 1'b0, out_seen = 1'b0;
    bit          snd_quiet = 1'b0, rcv_quiet = 1'b0;
    int unsigned gap_left = 0, stall_left = 0, quiet_cyc = 0;
    int          err_cnt = 0, n_items = 0, n_frames = 0, n_ignored = 0, n_settings = 0;

    ir_aircon_frame_transmitter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned eff_period();
        return (tmg.period < MIN_PERIOD) ? MIN_PERIOD : tmg.period;
    endfunction

    function automatic int unsigned gap_len(logic [LEN_W-1:0] us);
        return (us == '0) ? 1 : us;
    endfunction

    function automatic int unsigned burst_len(logic [LEN_W-1:0] us);
        int unsigned p, u;
        p = eff_period();
        u = gap_len(us);
        return ((u + p - 1) / p) * p;
    endfunction

    function automatic int unsigned bit_gap(int unsigned pos);
        return gap_len(frame_img[pos >> 3][pos & 7] ? tmg.one_gap : tmg.zero_gap);
    endfunction

    function automatic t_out_item ir_wave_step(t_in_item it);
        t_out_item   r;
        int unsigned p, sum;
        r = '0;
        if (it.kind) begin
            r.busy_res = 1'b1;
            if (seq_ph != PH_IDLE) begin
                r.send_ignored = 1'b1;
            end else begin
                frame_img     = '{default: 8'h00};
                frame_img[0]  = HDR_BYTE0;
                frame_img[1]  = HDR_BYTE1;
                frame_img[2]  = HDR_BYTE2;
                frame_img[3]  = CMD_BYTE3;
                frame_img[5]  = it.power_code;
                frame_img[6]  = it.mode_code;
                frame_img[7]  = {3'b000, TEMP_TOP - it.temperature};
                frame_img[8]  = it.fan_speed_code | it.vane_vert_code;
                frame_img[12] = it.vane_horz_code;
                sum = 0;
                for (int i = 0; i < 13; i++) sum += frame_img[i];
                frame_img[13] = 8'(sum);
                seq_ph     = PH_HDR_MARK;
                bit_pos    = 0;
                ticks_left = burst_len(tmg.hdr_burst);
                car_ph     = 0;
            end
        end else if (seq_ph != PH_IDLE) begin
            r.busy_res = 1'b1;
            if (seq_ph == PH_HDR_MARK || seq_ph == PH_LEAD_MARK || seq_ph == PH_BIT_MARK) begin
                p = eff_period();
                if (car_ph >= p) car_ph = 0;
                r.led_level = (car_ph < p / 2);
                car_ph = (car_ph + 1 >= p) ? 0 : car_ph + 1;
            end
            if (ticks_left > 0) ticks_left--;
            if (ticks_left == 0) begin
                case (seq_ph)
                    PH_HDR_MARK: begin
                        seq_ph     = PH_HDR_SPACE;
                        ticks_left = gap_len(tmg.hdr_gap);
                    end
                    PH_HDR_SPACE: begin
                        seq_ph     = PH_LEAD_MARK;
                        ticks_left = burst_len(tmg.bit_burst);
                        car_ph     = 0;
                    end
                    PH_LEAD_MARK: begin
                        seq_ph     = PH_BIT_SPACE;
                        bit_pos    = 0;
                        ticks_left = bit_gap(bit_pos);
                    end
                    PH_BIT_SPACE: begin
                        seq_ph     = PH_BIT_MARK;
                        ticks_left = burst_len(tmg.bit_burst);
                        car_ph     = 0;
                    end
                    default: begin
                        bit_pos++;
                        if (bit_pos >= FRAME_N * 8) begin
                            seq_ph      = PH_IDLE;
                            bit_pos     = 0;
                            car_ph      = 0;
                            r.frame_end = 1'b1;
                        end else begin
                            seq_ph     = PH_BIT_SPACE;
                            ticks_left = bit_gap(bit_pos);
                        end
                    end
                endcase
            end
        end
        return r;
    endfunction

    function automatic int unsigned hold_off(bit quiet);
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic t_in_item rand_item(bit kind);
        logic [63:0] rnd;
        t_in_item    it;
        rnd     = {$urandom, $urandom};
        it      = rnd[$bits(t_in_item)-1:0];
        it.kind = kind;
        return it;
    endfunction

    task automatic check_field(string name, logic want, logic got);
        if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_PRINTS)
                $display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
        end
    endtask

    // sender: hold a stalled item, otherwise wait out the gap and present the next
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0) snd_quiet = ~snd_quiet;
        if (!i_in_valid || in_took) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (tx_item_q.size() != 0) begin
                i_in_data  <= tx_item_q.pop_front();
                i_in_valid <= 1'b1;
                gap_left   = hold_off(snd_quiet);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0) rcv_quiet = ~rcv_quiet;
        if (out_took) stall_left = hold_off(rcv_quiet);
        else if (out_seen && stall_left > 0) stall_left--;
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin : mon
        t_out_item want;
        logic      in_acc, out_acc;
        if (!i_rst_n) begin
            in_took  <= 1'b0;
            out_took <= 1'b0;
            out_seen <= 1'b0;
        end else begin
            in_acc   = i_in_valid && !o_in_stall;
            out_acc  = o_out_valid && !i_out_stall;
            in_took  <= in_acc;
            out_took <= out_acc;
            out_seen <= o_out_valid;
            if (out_acc) begin
                if (exp_wave_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_PRINTS)
                        $display("%0t: unexpected result, expected none, got %b",
                                 $time, o_out_data);
                end else begin
                    want = exp_wave_q.pop_front();
                    check_field("led_level", want.led_level, o_out_data.led_level);
                    check_field("busy_res", want.busy_res, o_out_data.busy_res);
                    check_field("frame_end", want.frame_end, o_out_data.frame_end);
                    check_field("send_ignored", want.send_ignored, o_out_data.send_ignored);
                end
            end
            if (in_acc) begin
                want = ir_wave_step(i_in_data);
                exp_wave_q.push_back(want);
                n_items++;
                if (want.frame_end) n_frames++;
                if (want.send_ignored) n_ignored++;
            end
            if (in_acc || out_acc) quiet_cyc = 0;
            else quiet_cyc++;
            if (quiet_cyc == WDOG_LIMIT) begin
                $display("%0t: watchdog, no handshake for %0d cycles", $time, WDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (tx_item_q.size() != 0 || i_in_valid || exp_wave_q.size() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_HDR_MARK:   tmg.hdr_burst = val;
            CFG_HDR_SPACE:  tmg.hdr_gap   = val;
            CFG_ONE_SPACE:  tmg.one_gap   = val;
            CFG_ZERO_SPACE: tmg.zero_gap  = val;
            CFG_BIT_MARK:   tmg.bit_burst = val;
            CFG_PERIOD:     tmg.period    = val[PER_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timing(t_timing t);
        logic [CFG_DATA_W-PER_W-1:0] junk;
        junk = $urandom;
        cfg_write(CFG_HDR_MARK, t.hdr_burst);
        cfg_write(CFG_HDR_SPACE, t.hdr_gap);
        cfg_write(CFG_ONE_SPACE, t.one_gap);
        cfg_write(CFG_ZERO_SPACE, t.zero_gap);
        cfg_write(CFG_BIT_MARK, t.bit_burst);
        cfg_write(CFG_PERIOD, {junk, t.period});
        n_settings++;
    endtask

    // tick until the frame is out, with stray sends and retiming between bursts
    task automatic finish_frame();
        logic [CFG_IDX_W-1:0] idx;
        wait_drained();
        while (seq_ph != PH_IDLE) begin
            for (int k = 0; k < 32; k++)
                tx_item_q.push_back(rand_item($urandom_range(0, 39) == 0));
            wait_drained();
            if ($urandom_range(0, 2) == 0) begin
                idx = CFG_IDX_W'($urandom_range(CFG_HDR_MARK, CFG_PERIOD));
                cfg_write(idx, (idx == CFG_PERIOD) ? CFG_DATA_W'($urandom_range(0, 3))
                                                   : CFG_DATA_W'($urandom_range(0, 2)));
            end
        end
    endtask

    initial begin
        t_in_item it;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle ticks straight out of reset
        tx_item_q.push_back('0);
        it = '1;
        it.kind = 1'b0;
        tx_item_q.push_back(it);
        wait_drained();

        // zero lengths and a zero period: full-scale send, then a send while busy
        set_timing('0);
        tx_item_q.push_back('1);
        it = '0;
        it.kind = 1'b1;
        tx_item_q.push_back(it);
        finish_frame();

        // maximum lengths and period: start of the header burst, then shrink
        // the period mid-burst so the carrier phase wraps
        set_timing('{'1, '1, '1, '1, '1, '1});
        tx_item_q.push_back(rand_item(1'b1));
        repeat (40) tx_item_q.push_back(rand_item($urandom_range(0, 19) == 0));
        wait_drained();
        cfg_write(CFG_PERIOD, 14'd3);
        repeat (30) tx_item_q.push_back(rand_item($urandom_range(0, 19) == 0));
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (exp_wave_q.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d results still expected", $time, exp_wave_q.size());
        end
        $display("Sent %0d items over %0d timing settings: %0d frames finished, %0d sends ignored",
                 n_items, n_settings, n_frames, n_ignored);
        $display("Errors found: %0d", err_cnt);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
